### rtl/sbcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcd_pkg
// Shared types and constants of the signed BCD arithmetic unit.
// ----------------------------------------------------------------------------
package sbcd_pkg;

  localparam int unsigned DATA_W = 64;

  localparam logic [3:0] DIGIT_MAX = 4'd9;
  localparam logic [4:0] RADIX     = 5'd10;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    CMP_LESS    = 2'd0,
    CMP_EQUAL   = 2'd1,
    CMP_GREATER = 2'd2
  } cmp_e;

  typedef struct packed {
    logic [2:0]        operation;
    logic [DATA_W-1:0] a_digits;
    logic              a_negative;
    logic [DATA_W-1:0] b_digits;
    logic              b_negative;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_digits;
    logic              result_negative;
    logic [1:0]        compare_outcome;
    logic              overflow;
    logic              divide_by_zero;
  } out_word_t;

endpackage

### rtl/sbcd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcd channel interfaces
// Valid/ready channels carrying the operand word and the result word.
// ----------------------------------------------------------------------------
interface sbcd_in_if;
  logic               valid;
  logic               ready;
  sbcd_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface sbcd_out_if;
  logic                valid;
  logic                ready;
  sbcd_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### rtl/sbcd_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbcd_adder
// Word-wide BCD adder/subtractor; subtract adds the nines complement plus one.
// ----------------------------------------------------------------------------
module sbcd_adder #(
  parameter int unsigned NDIG = 17
) (
  input  logic [4*NDIG-1:0] a_i,
  input  logic [4*NDIG-1:0] b_i,
  input  logic              sub_i,
  output logic [4*NDIG-1:0] sum_o,
  output logic              carry_o
);

  logic [3:0]      b_dig  [NDIG];
  logic [4:0]      raw    [NDIG];
  logic [4:0]      fixed  [NDIG];
  logic [NDIG-1:0] gen;
  logic [NDIG-1:0] prop;
  logic [NDIG:0]   csum;
  logic [NDIG-1:0] cin;

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      b_dig[k] = sub_i ? (sbcd_pkg::DIGIT_MAX - b_i[4*k +: 4]) : b_i[4*k +: 4];
      raw[k]   = {1'b0, a_i[4*k +: 4]} + {1'b0, b_dig[k]};
      gen[k]   = raw[k] >= sbcd_pkg::RADIX;
      // digit sum of nine or more passes an incoming carry on
      prop[k]  = raw[k] >= {1'b0, sbcd_pkg::DIGIT_MAX};
    end
  end

  // resolve the decimal carry chain with one binary add over the digit flags
  assign csum    = {1'b0, gen} + {1'b0, prop} + {{NDIG{1'b0}}, sub_i};
  assign cin     = csum[NDIG-1:0] ^ gen ^ prop;
  assign carry_o = csum[NDIG];

  always_comb begin
    for (int k = 0; k < NDIG; k++) begin
      fixed[k] = raw[k] + {4'd0, cin[k]};
      sum_o[4*k +: 4] = (fixed[k] >= sbcd_pkg::RADIX) ?
                        4'(fixed[k] - sbcd_pkg::RADIX) : fixed[k][3:0];
    end
  end

endmodule

### rtl/signed_bcd_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_bcd_arithmetic_unit_top
// Sign-magnitude BCD add, subtract, multiply, divide and compare on a
// single shared word-wide BCD adder driven by a small sequencer.
// ----------------------------------------------------------------------------
// After acceptance: two normalize passes and a dispatch step, then add/subtract in one
//   adder pass, a second when the first subtraction borrows; compare in one subtract
//   pass unless the signs differ; multiply and divide per digit one shift, one adder pass
//   per unit and one more; divide by zero and unknown codes skip to the finish step,
//   which loads the result register and waits while it is held full. One word at a time.
// Reset: control registers clear asynchronously; no clearing pass.
// ----------------------------------------------------------------------------
module signed_bcd_arithmetic_unit_top #(
  parameter int unsigned DIGITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  sbcd_in_if.sink           in_i,
  sbcd_out_if.source        out_o
);

  localparam int unsigned DW    = 4 * DIGITS;
  localparam int unsigned WW    = DW + 4;
  localparam int unsigned CNT_W = $clog2(DIGITS);

  typedef enum logic [11:0] {
    ST_IDLE      = 12'h001,
    ST_NORM_A    = 12'h002,
    ST_NORM_B    = 12'h004,
    ST_DISPATCH  = 12'h008,
    ST_ADD       = 12'h010,
    ST_SUB1      = 12'h020,
    ST_SUB2      = 12'h040,
    ST_MUL_SHIFT = 12'h080,
    ST_MUL_ADD   = 12'h100,
    ST_DIV_SHIFT = 12'h200,
    ST_DIV_SUB   = 12'h400,
    ST_FINISH    = 12'h800
  } state_e;

  state_e              state_q, state_d;
  logic [2:0]          op_q, op_d;
  logic                an_q, an_d;
  logic                bn_q, bn_d;
  logic [DW-1:0]       x_q, x_d;
  logic [DW-1:0]       y_q, y_d;
  logic [WW-1:0]       acc_q, acc_d;
  logic [DW-1:0]       mag_q, mag_d;
  logic                neg_q, neg_d;
  logic [1:0]          cmp_q, cmp_d;
  logic                ovf_q, ovf_d;
  logic                dz_q, dz_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [3:0]          qd_q, qd_d;
  logic                out_valid_q, out_valid_d;
  sbcd_pkg::out_word_t out_q, out_d;

  logic [WW-1:0]       ua, ub, us;
  logic                usub, uc;
  logic [CNT_W-1:0]    idx;
  logic                last_digit;

  // split each nibble into a proper digit and a carry into the next digit
  function automatic logic [DW-1:0] norm_lo(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    r = '0;
    for (int k = 0; k < DIGITS; k++) begin
      r[4*k +: 4] = (v[4*k +: 4] > sbcd_pkg::DIGIT_MAX) ?
                    4'(v[4*k +: 4] - sbcd_pkg::RADIX[3:0]) : v[4*k +: 4];
    end
    return r;
  endfunction

  function automatic logic [DW-1:0] norm_hi(input logic [DW-1:0] v);
    logic [DW-1:0] r;
    r = '0;
    for (int k = 0; k < DIGITS - 1; k++) begin
      r[4*(k+1)] = v[4*k +: 4] > sbcd_pkg::DIGIT_MAX;
    end
    return r;
  endfunction

  assign idx        = CNT_W'(DIGITS - 1) - cnt_q;
  assign last_digit = cnt_q == CNT_W'(DIGITS - 1);

  // operand select for the shared adder
  always_comb begin
    ua   = '0;
    ub   = '0;
    usub = 1'b0;
    case (state_q)
      ST_NORM_A: begin
        ua = {4'd0, norm_lo(x_q)};
        ub = {4'd0, norm_hi(x_q)};
      end
      ST_NORM_B: begin
        ua = {4'd0, norm_lo(y_q)};
        ub = {4'd0, norm_hi(y_q)};
      end
      ST_ADD: begin
        ua = {4'd0, x_q};
        ub = {4'd0, y_q};
      end
      ST_SUB1: begin
        ua   = {4'd0, x_q};
        ub   = {4'd0, y_q};
        usub = 1'b1;
      end
      ST_SUB2: begin
        ua   = {4'd0, y_q};
        ub   = {4'd0, x_q};
        usub = 1'b1;
      end
      ST_MUL_ADD: begin
        ua = {4'd0, mag_q};
        ub = {4'd0, x_q};
      end
      ST_DIV_SUB: begin
        ua   = acc_q;
        ub   = {4'd0, y_q};
        usub = 1'b1;
      end
      default: begin
        ua = '0;
      end
    endcase
  end

  sbcd_adder #(
    .NDIG (DIGITS + 1)
  ) u_adder (
    .a_i     (ua),
    .b_i     (ub),
    .sub_i   (usub),
    .sum_o   (us),
    .carry_o (uc)
  );

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    an_d        = an_q;
    bn_d        = bn_q;
    x_d         = x_q;
    y_d         = y_q;
    acc_d       = acc_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    cmp_d       = cmp_q;
    ovf_d       = ovf_q;
    dz_d        = dz_q;
    cnt_d       = cnt_q;
    qd_d        = qd_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          op_d    = in_i.data.operation;
          an_d    = in_i.data.a_negative;
          bn_d    = in_i.data.b_negative;
          x_d     = in_i.data.a_digits[DW-1:0];
          y_d     = in_i.data.b_digits[DW-1:0];
          state_d = ST_NORM_A;
        end
      end
      ST_NORM_A: begin
        x_d     = us[DW-1:0];
        state_d = ST_NORM_B;
      end
      ST_NORM_B: begin
        y_d     = us[DW-1:0];
        state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        // zero operands never carry a sign
        an_d  = an_q && (x_q != '0);
        bn_d  = bn_q && (y_q != '0);
        if (op_q == sbcd_pkg::OP_SUB) begin
          bn_d = !bn_q && (y_q != '0);
        end
        mag_d = '0;
        neg_d = 1'b0;
        cmp_d = sbcd_pkg::CMP_LESS;
        ovf_d = 1'b0;
        dz_d  = 1'b0;
        cnt_d = '0;
        acc_d = '0;
        case (op_q)
          sbcd_pkg::OP_ADD, sbcd_pkg::OP_SUB: begin
            state_d = (an_d == bn_d) ? ST_ADD : ST_SUB1;
          end
          sbcd_pkg::OP_CMP: begin
            if (an_d != bn_d) begin
              cmp_d   = an_d ? sbcd_pkg::CMP_LESS : sbcd_pkg::CMP_GREATER;
              state_d = ST_FINISH;
            end else begin
              state_d = ST_SUB1;
            end
          end
          sbcd_pkg::OP_MUL: begin
            neg_d   = an_d ^ bn_d;
            state_d = ST_MUL_SHIFT;
          end
          sbcd_pkg::OP_DIV: begin
            if (y_q == '0) begin
              dz_d    = 1'b1;
              state_d = ST_FINISH;
            end else begin
              neg_d   = an_d ^ bn_d;
              state_d = ST_DIV_SHIFT;
            end
          end
          default: begin
            state_d = ST_FINISH;
          end
        endcase
      end
      ST_ADD: begin
        mag_d   = us[DW-1:0];
        ovf_d   = us[WW-1:DW] != 4'd0;
        neg_d   = an_q;
        state_d = ST_FINISH;
      end
      ST_SUB1: begin
        state_d = ST_FINISH;
        if (op_q == sbcd_pkg::OP_CMP) begin
          if (!uc) begin
            cmp_d = an_q ? sbcd_pkg::CMP_GREATER : sbcd_pkg::CMP_LESS;
          end else if (us == '0) begin
            cmp_d = sbcd_pkg::CMP_EQUAL;
          end else begin
            cmp_d = an_q ? sbcd_pkg::CMP_LESS : sbcd_pkg::CMP_GREATER;
          end
        end else if (uc) begin
          mag_d = us[DW-1:0];
          neg_d = an_q;
        end else begin
          state_d = ST_SUB2;
        end
      end
      ST_SUB2: begin
        mag_d   = us[DW-1:0];
        neg_d   = bn_q;
        state_d = ST_FINISH;
      end
      ST_MUL_SHIFT: begin
        // a digit pushed out of the top means the product no longer fits
        ovf_d   = ovf_q || (mag_q[DW-1 -: 4] != 4'd0);
        mag_d   = {mag_q[DW-5:0], 4'd0};
        qd_d    = y_q[4*idx +: 4];
        state_d = ST_MUL_ADD;
      end
      ST_MUL_ADD: begin
        if (qd_q != 4'd0) begin
          mag_d = us[DW-1:0];
          ovf_d = ovf_q || (us[WW-1:DW] != 4'd0);
          qd_d  = qd_q - 4'd1;
        end else if (last_digit) begin
          state_d = ST_FINISH;
        end else begin
          cnt_d   = cnt_q + CNT_W'(1);
          state_d = ST_MUL_SHIFT;
        end
      end
      ST_DIV_SHIFT: begin
        acc_d   = {acc_q[WW-5:0], x_q[4*idx +: 4]};
        qd_d    = 4'd0;
        state_d = ST_DIV_SUB;
      end
      ST_DIV_SUB: begin
        if (uc) begin
          acc_d = us;
          qd_d  = qd_q + 4'd1;
        end else begin
          mag_d = {mag_q[DW-5:0], qd_q};
          if (last_digit) begin
            state_d = ST_FINISH;
          end else begin
            cnt_d   = cnt_q + CNT_W'(1);
            state_d = ST_DIV_SHIFT;
          end
        end
      end
      ST_FINISH: begin
        // hold until the result register is free or drains this cycle
        if (!out_valid_q || out_o.ready) begin
          out_d.result_digits   = sbcd_pkg::DATA_W'(mag_q);
          out_d.result_negative = neg_q && (mag_q != '0);
          out_d.compare_outcome = cmp_q;
          out_d.overflow        = ovf_q;
          out_d.divide_by_zero  = dz_q;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      qd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      qd_q        <= qd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    an_q  <= an_d;
    bn_q  <= bn_d;
    x_q   <= x_d;
    y_q   <= y_d;
    acc_q <= acc_d;
    mag_q <= mag_d;
    neg_q <= neg_d;
    cmp_q <= cmp_d;
    ovf_q <= ovf_d;
    dz_q  <= dz_d;
    out_q <= out_d;
  end

  assign in_i.ready  = state_q == ST_IDLE;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef SYNTHESIS
  a_accept_starts_norm : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> state_q == ST_NORM_A)
    else $error("accepted word did not start normalization");

  a_quotient_digit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV_SUB |-> qd_q <= sbcd_pkg::DIGIT_MAX)
    else $error("quotient digit above nine");

  a_no_negative_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.result_negative |-> out_o.data.result_digits != '0)
    else $error("negative zero result");

  a_div_zero_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.divide_by_zero |->
      out_o.data.result_digits == '0 && !out_o.data.overflow)
    else $error("divide by zero result not cleared");

  a_compare_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.compare_outcome != sbcd_pkg::CMP_LESS |->
      out_o.data.result_digits == '0 && !out_o.data.overflow)
    else $error("compare result carries a magnitude");
`endif

endmodule

### tb/sv/tb_signed_bcd_arithmetic_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_bcd_arithmetic_unit_top
// Self-checking bench for the signed BCD arithmetic unit. The bench drives
// directed corner cases and then random operand words in bursts. The receiver
// stalls at random and holds off once for a long stretch. Every result word
// is checked field by field against an in-bench decimal predictor.
// ----------------------------------------------------------------------------
module tb_signed_bcd_arithmetic_unit_top;

  localparam int unsigned DIGIT_COUNT     = 16;
  localparam int unsigned RANDOM_ITEMS    = 1625;
  localparam int unsigned HOLD_OFF_CYCLES = 1500;
  localparam int unsigned HOLD_OFF_AFTER  = 150;
  localparam int unsigned DRAIN_CYCLES    = 250;
  localparam int unsigned STALL_LIMIT     = 6000;

  class bcd_result_scoreboard;
    sbcd_pkg::out_word_t         expected_results[$];
    int unsigned                 failures;
    int unsigned                 noted;
    logic [sbcd_pkg::DATA_W-1:0] modulus;

    function new();
      failures = 0;
      noted    = 0;
      modulus  = 64'd1;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        modulus = modulus * sbcd_pkg::RADIX;
      end
    endfunction

    // Odd nibbles keep their binary value at their decimal weight.
    function logic [sbcd_pkg::DATA_W-1:0] decimal_value(logic [sbcd_pkg::DATA_W-1:0] digits);
      logic [sbcd_pkg::DATA_W-1:0] v;
      v = '0;
      for (int i = DIGIT_COUNT - 1; i >= 0; i--) begin
        v = (v * sbcd_pkg::RADIX + digits[4*i +: 4]) % modulus;
      end
      return v;
    endfunction

    function logic [sbcd_pkg::DATA_W-1:0] packed_digits(logic [sbcd_pkg::DATA_W-1:0] value);
      logic [sbcd_pkg::DATA_W-1:0] r;
      r = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
        r[4*i +: 4] = 4'(value % sbcd_pkg::RADIX);
        value = value / sbcd_pkg::RADIX;
      end
      return r;
    endfunction

    function sbcd_pkg::out_word_t predict_result(sbcd_pkg::in_word_t w);
      sbcd_pkg::out_word_t         r;
      logic [sbcd_pkg::DATA_W-1:0] a_val, b_val, mag;
      logic [127:0]                product;
      logic                        a_neg, b_neg, neg;
      a_val   = decimal_value(w.a_digits);
      b_val   = decimal_value(w.b_digits);
      a_neg   = w.a_negative && (a_val != 0);
      b_neg   = w.b_negative && (b_val != 0);
      mag     = '0;
      neg     = 1'b0;
      r       = '0;
      case (w.operation)
        sbcd_pkg::OP_ADD, sbcd_pkg::OP_SUB: begin
          if (w.operation == sbcd_pkg::OP_SUB) b_neg = (b_val != 0) && !b_neg;
          if (a_neg == b_neg) begin
            mag = a_val + b_val;
            if (mag >= modulus) begin
              mag        = mag - modulus;
              r.overflow = 1'b1;
            end
            neg = a_neg;
          end else if (a_val >= b_val) begin
            mag = a_val - b_val;
            neg = a_neg;
          end else begin
            mag = b_val - a_val;
            neg = b_neg;
          end
        end
        sbcd_pkg::OP_MUL: begin
          product    = {64'd0, a_val} * {64'd0, b_val};
          r.overflow = (product >= {64'd0, modulus});
          product    = product % {64'd0, modulus};
          mag        = product[sbcd_pkg::DATA_W-1:0];
          neg        = a_neg != b_neg;
        end
        sbcd_pkg::OP_DIV: begin
          if (b_val == 0) begin
            r.divide_by_zero = 1'b1;
          end else begin
            mag = a_val / b_val;
            neg = a_neg != b_neg;
          end
        end
        sbcd_pkg::OP_CMP: begin
          if (a_neg != b_neg) begin
            r.compare_outcome = a_neg ? sbcd_pkg::CMP_LESS : sbcd_pkg::CMP_GREATER;
          end else if (a_val == b_val) begin
            r.compare_outcome = sbcd_pkg::CMP_EQUAL;
          end else begin
            r.compare_outcome = ((a_val < b_val) != a_neg) ?
                                sbcd_pkg::CMP_LESS : sbcd_pkg::CMP_GREATER;
          end
        end
        default: ;
      endcase
      r.result_digits   = packed_digits(mag);
      r.result_negative = neg && (mag != 0);
      return r;
    endfunction

    function void note_operands(sbcd_pkg::in_word_t w);
      expected_results.push_back(predict_result(w));
      noted++;
    endfunction

    function void check_result(sbcd_pkg::out_word_t got);
      sbcd_pkg::out_word_t want;
      if (expected_results.size() == 0) begin
        $error("unexpected result word %h", got);
        failures++;
        return;
      end
      want = expected_results.pop_front();
      if (got.result_digits !== want.result_digits) begin
        $error("result_digits: expected %h, got %h",
               want.result_digits, got.result_digits);
        failures++;
      end
      if (got.result_negative !== want.result_negative) begin
        $error("result_negative: expected %b, got %b",
               want.result_negative, got.result_negative);
        failures++;
      end
      if (got.compare_outcome !== want.compare_outcome) begin
        $error("compare_outcome: expected %0d, got %0d",
               want.compare_outcome, got.compare_outcome);
        failures++;
      end
      if (got.overflow !== want.overflow) begin
        $error("overflow: expected %b, got %b", want.overflow, got.overflow);
        failures++;
      end
      if (got.divide_by_zero !== want.divide_by_zero) begin
        $error("divide_by_zero: expected %b, got %b",
               want.divide_by_zero, got.divide_by_zero);
        failures++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sbcd_in_if  in_if ();
  sbcd_out_if out_if ();

  bcd_result_scoreboard board;
  int unsigned          burst_left;
  int unsigned          idle_cycles;

  signed_bcd_arithmetic_unit_top #(
    .DIGITS (DIGIT_COUNT)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Mostly short well-formed numbers, with zeros, all nines and raw nibbles mixed in.
  function automatic logic [sbcd_pkg::DATA_W-1:0] random_magnitude();
    logic [sbcd_pkg::DATA_W-1:0] v;
    int unsigned                 pick, len;
    v    = '0;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      v = {$urandom, $urandom};
    end else if (pick < 14) begin
      v = '0;
    end else if (pick < 20) begin
      for (int i = 0; i < DIGIT_COUNT; i++) v[4*i +: 4] = sbcd_pkg::DIGIT_MAX;
    end else begin
      len = (pick < 60) ? $urandom_range(1, 5) : $urandom_range(1, DIGIT_COUNT);
      for (int i = 0; i < len; i++) begin
        v[4*i +: 4] = 4'($urandom_range(0, sbcd_pkg::DIGIT_MAX));
      end
    end
    return v;
  endfunction

  task automatic push_operands(input logic [2:0] op, input logic [sbcd_pkg::DATA_W-1:0] a,
                               input logic an, input logic [sbcd_pkg::DATA_W-1:0] b,
                               input logic bn);
    sbcd_pkg::in_word_t w;
    w.operation  = op;
    w.a_digits   = a;
    w.a_negative = an;
    w.b_digits   = b;
    w.b_negative = bn;
    in_if.data   = w;
    in_if.valid  = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_operands(w);
    @(negedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // end of burst: drop valid for a gap, then start the next burst
      burst_left  = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      in_if.valid = 1'b0;
      repeat (($urandom_range(0, 4) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 15))
        @(negedge clk_i);
    end
  endtask

  initial begin
    logic [2:0]                  op;
    logic [sbcd_pkg::DATA_W-1:0] a, b;
    board       = new();
    burst_left  = 0;
    rst_ni      = 1'b0;
    in_if.valid = 1'b0;
    in_if.data  = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    push_operands(sbcd_pkg::OP_ADD, 64'h9999_9999_9999_9999, 1'b0,
                  64'h9999_9999_9999_9999, 1'b0);
    push_operands(sbcd_pkg::OP_ADD, 64'h9999_9999_9999_9999, 1'b1, 64'h1, 1'b1);
    push_operands(sbcd_pkg::OP_ADD, 64'h1234_5678, 1'b0, 64'h1234_5678, 1'b1);
    push_operands(sbcd_pkg::OP_ADD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0, 1'b0);
    push_operands(sbcd_pkg::OP_SUB, 64'h0, 1'b0, 64'h1, 1'b0);
    push_operands(sbcd_pkg::OP_SUB, 64'h1000_0000, 1'b0, 64'h1, 1'b0);
    push_operands(sbcd_pkg::OP_SUB, 64'h25, 1'b1, 64'h70, 1'b1);
    push_operands(sbcd_pkg::OP_SUB, 64'h9999_9999_9999_9999, 1'b1, 64'h2, 1'b0);
    push_operands(sbcd_pkg::OP_SUB, 64'h0, 1'b1, 64'h0, 1'b1);
    push_operands(sbcd_pkg::OP_MUL, 64'h9999_9999_9999_9999, 1'b0,
                  64'h9999_9999_9999_9999, 1'b1);
    push_operands(sbcd_pkg::OP_MUL, 64'h0, 1'b0, 64'h5, 1'b1);
    push_operands(sbcd_pkg::OP_MUL, 64'h1000_0000_0000_0000, 1'b1, 64'h10, 1'b0);
    push_operands(sbcd_pkg::OP_MUL, 64'h1234, 1'b1, 64'h5678, 1'b0);
    push_operands(sbcd_pkg::OP_DIV, 64'h42, 1'b0, 64'h0, 1'b0);
    push_operands(sbcd_pkg::OP_DIV, 64'h9999, 1'b1, 64'h0, 1'b1);
    push_operands(sbcd_pkg::OP_DIV, 64'h7, 1'b1, 64'h2, 1'b0);
    push_operands(sbcd_pkg::OP_DIV, 64'h3, 1'b1, 64'h9999_9999_9999_9999, 1'b0);
    push_operands(sbcd_pkg::OP_DIV, 64'h9999_9999_9999_9999, 1'b0, 64'h1, 1'b1);
    push_operands(sbcd_pkg::OP_CMP, 64'h0, 1'b1, 64'h0, 1'b0);
    push_operands(sbcd_pkg::OP_CMP, 64'h3, 1'b1, 64'h2, 1'b0);
    push_operands(sbcd_pkg::OP_CMP, 64'h3, 1'b1, 64'h5, 1'b1);
    push_operands(sbcd_pkg::OP_CMP, 64'h5, 1'b0, 64'h12, 1'b0);
    push_operands(sbcd_pkg::OP_CMP, 64'h9999_9999_9999_9999, 1'b1,
                  64'h9999_9999_9999_9999, 1'b1);
    push_operands(3'(sbcd_pkg::OP_CMP) + 3'd1, 64'h1, 1'b1, 64'h2, 1'b0);
    push_operands(3'h7, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);

    repeat (RANDOM_ITEMS) begin
      if ($urandom_range(0, 49) == 0) begin
        op = 3'($urandom_range(3'(sbcd_pkg::OP_CMP) + 1, 7));
      end else begin
        op = 3'($urandom_range(sbcd_pkg::OP_ADD, sbcd_pkg::OP_CMP));
      end
      a = random_magnitude();
      b = ($urandom_range(0, 6) == 0) ? a : random_magnitude();
      push_operands(op, a, 1'($urandom_range(0, 1)), b, 1'($urandom_range(0, 1)));
    end
    in_if.valid = 1'b0;

    while (board.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.failures == 0 && board.expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Receiver: random segments of steady, random and patterned ready, plus one long hold-off.
  initial begin
    int unsigned seg_len, mode, phase;
    bit          held;
    held         = 1'b0;
    phase        = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      seg_len = $urandom_range(10, 150);
      mode    = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(negedge clk_i);
        phase++;
        if (!held && board.noted >= HOLD_OFF_AFTER) begin
          // hold off while the sender keeps offering words
          held         = 1'b1;
          out_if.ready = 1'b0;
          repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
        end else begin
          case (mode)
            0:       out_if.ready = 1'b1;
            1:       out_if.ready = 1'($urandom_range(0, 1));
            2:       out_if.ready = (phase % 4 == 0);
            default: out_if.ready = ($urandom_range(0, 7) != 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) board.check_result(out_if.data);
  end

  // Watchdog: count cycles in which neither side moves a word.
  initial idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### signed_bcd_arithmetic_unit_top.f
rtl/sbcd_pkg.sv
rtl/sbcd_if.sv
rtl/sbcd_adder.sv
rtl/signed_bcd_arithmetic_unit_top.sv
tb/sv/tb_signed_bcd_arithmetic_unit_top.sv
